[hdl/hpc_pkg.sv]
// Shared types, constants and profile tables for the heater profile controller.
package hpc_pkg;

    localparam int unsigned PROFILES      = 5;
    localparam int unsigned MS_PER_SECOND = 1000;

    localparam logic [2:0]  MENU_LAST  = 3'(PROFILES - 1);
    localparam logic [9:0]  ADC_RAIL_LO = 10'd0;
    localparam logic [9:0]  ADC_RAIL_HI = 10'd1023;
    localparam logic [3:0]  STREAK_MAX  = 4'd15;

    localparam logic [31:0] SEC_MS     = 32'(MS_PER_SECOND);
    localparam logic [31:0] SEC_MS_X2  = 32'(2 * MS_PER_SECOND);
    localparam logic [31:0] SEC_MS_X3  = 32'(3 * MS_PER_SECOND);
    localparam logic [31:0] SEC_RECIP  = 32'(64'h0000_0000_FFFF_FFFF / 64'(MS_PER_SECOND));

    localparam logic [1:0] CFG_HYST          = 2'd0;
    localparam logic [1:0] CFG_MAX_SAFE      = 2'd1;
    localparam logic [1:0] CFG_FAULT_SAMPLES = 2'd2;

    localparam logic [2:0] MODE_CODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_CODE_MENU  = 3'd1;
    localparam logic [2:0] MODE_CODE_RUN   = 3'd2;
    localparam logic [2:0] MODE_CODE_DONE  = 3'd3;
    localparam logic [2:0] MODE_CODE_FAULT = 3'd4;

    localparam logic [10:0] PROF_SET_DECI [8] = '{
        11'd450, 11'd650, 11'd650, 11'd500, 11'd750, 11'd750, 11'd750, 11'd750
    };
    localparam logic [15:0] PROF_DUR_S [8] = '{
        16'd14400, 16'd21600, 16'd21600, 16'd21600,
        16'd43200, 16'd43200, 16'd43200, 16'd43200
    };
    localparam logic [47:0] PROF_LIMIT_MS [8] = '{
        48'(PROF_DUR_S[0]) * 48'(MS_PER_SECOND), 48'(PROF_DUR_S[1]) * 48'(MS_PER_SECOND),
        48'(PROF_DUR_S[2]) * 48'(MS_PER_SECOND), 48'(PROF_DUR_S[3]) * 48'(MS_PER_SECOND),
        48'(PROF_DUR_S[4]) * 48'(MS_PER_SECOND), 48'(PROF_DUR_S[5]) * 48'(MS_PER_SECOND),
        48'(PROF_DUR_S[6]) * 48'(MS_PER_SECOND), 48'(PROF_DUR_S[7]) * 48'(MS_PER_SECOND)
    };

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_MENU  = 5'b00010,
        MODE_RUN   = 5'b00100,
        MODE_DONE  = 5'b01000,
        MODE_FAULT = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0]  hysteresis_deci;
        logic [10:0] max_safe_deci;
        logic [3:0]  fault_samples;
    } t_cfg;

    typedef struct packed {
        logic [9:0]         adc_code;
        logic signed [12:0] temp_deci;
        logic [31:0]        now_ms;
        logic               press_up;
        logic               press_down;
        logic               press_ok;
        logic               press_back;
    } t_tick;

    typedef struct packed {
        logic        heater_drive;
        logic [2:0]  mode_now;
        logic [2:0]  menu_pos;
        logic        sensor_fault;
        logic        is_run;
        logic [31:0] elapsed_ms;
        logic [15:0] dur_s;
    } t_stage;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_MENU:  c = MODE_CODE_MENU;
            MODE_RUN:   c = MODE_CODE_RUN;
            MODE_DONE:  c = MODE_CODE_DONE;
            MODE_FAULT: c = MODE_CODE_FAULT;
            default:    c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

[hdl/hpc_tick_if.sv]
// Tick channel: one sensor sample with press events per word.
interface hpc_tick_if;
    logic               valid;
    logic               ready;
    logic [9:0]         adc_code;
    logic signed [12:0] temp_deci;
    logic [31:0]        now_ms;
    logic               press_up;
    logic               press_down;
    logic               press_ok;
    logic               press_back;

    modport source (
        output valid, adc_code, temp_deci, now_ms, press_up, press_down, press_ok, press_back,
        input  ready
    );
    modport sink (
        input  valid, adc_code, temp_deci, now_ms, press_up, press_down, press_ok, press_back,
        output ready
    );
endinterface

[hdl/hpc_result_if.sv]
// Result channel: heater drive, mode and status per word.
interface hpc_result_if;
    logic        valid;
    logic        ready;
    logic        heater_drive;
    logic [2:0]  mode_now;
    logic [2:0]  menu_pos;
    logic [15:0] seconds_left;
    logic        sensor_fault;

    modport source (
        output valid, heater_drive, mode_now, menu_pos, seconds_left, sensor_fault,
        input  ready
    );
    modport sink (
        input  valid, heater_drive, mode_now, menu_pos, seconds_left, sensor_fault,
        output ready
    );
endinterface

[hdl/hpc_cfg.sv]
// Configuration register file for hysteresis, overtemperature limit and fault count.
module hpc_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [10:0]   i_cfg_data,
    output hpc_pkg::t_cfg o_cfg
);
    import hpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hysteresis_deci <= 8'd20;
            r_cfg.max_safe_deci   <= 11'd900;
            r_cfg.fault_samples   <= 4'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HYST:          r_cfg.hysteresis_deci <= i_cfg_data[7:0];
                CFG_MAX_SAFE:      r_cfg.max_safe_deci   <= i_cfg_data;
                CFG_FAULT_SAMPLES: r_cfg.fault_samples   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/hpc_core.sv]
// Input register, per-tick mode and heater logic, and the first result stage.
module hpc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hpc_tick_if.sink        i_tick,
    input  hpc_pkg::t_cfg   i_cfg,
    output logic            o_dn_valid,
    output hpc_pkg::t_stage o_dn,
    input  logic            i_dn_ready
);
    import hpc_pkg::*;

    logic        r_v0;
    t_tick       r_in;
    logic        r_v1;
    t_stage      r_res;

    t_mode       r_mode,  n_mode;
    logic [2:0]  r_menu,  n_menu;
    logic [2:0]  r_prof,  n_prof;
    logic [31:0] r_start, n_start;
    logic        r_heat,  n_heat;
    logic [3:0]  r_streak, n_streak;
    logic        r_therm, n_therm;

    logic               s_adv_a;
    logic               s_take;
    logic               s_valid_smp;
    logic [31:0]        s_elapsed;
    logic               s_timeout;
    logic signed [13:0] s_temp14;
    logic signed [13:0] s_sp;
    logic signed [13:0] s_hyst;
    logic signed [13:0] s_lo;
    logic signed [13:0] s_hi;
    logic signed [12:0] s_max_safe;
    t_stage             n_res;

    assign s_adv_a     = !r_v1 || i_dn_ready;
    assign s_take      = r_v0 && s_adv_a;
    assign i_tick.ready = !r_v0 || s_adv_a;

    assign s_valid_smp = (r_in.adc_code != ADC_RAIL_LO) && (r_in.adc_code != ADC_RAIL_HI);
    assign s_elapsed   = r_in.now_ms - r_start;
    assign s_timeout   = {16'd0, s_elapsed} >= PROF_LIMIT_MS[r_prof];
    assign s_temp14    = 14'(r_in.temp_deci);
    assign s_sp        = $signed({3'd0, PROF_SET_DECI[r_prof]});
    assign s_hyst      = $signed({6'd0, i_cfg.hysteresis_deci});
    assign s_lo        = s_sp - s_hyst;
    assign s_hi        = s_sp + s_hyst;
    assign s_max_safe  = $signed({2'd0, i_cfg.max_safe_deci});

    always_comb begin
        n_mode   = r_mode;
        n_menu   = r_menu;
        n_prof   = r_prof;
        n_start  = r_start;
        n_heat   = r_heat;
        n_streak = r_streak;
        n_therm  = r_therm;

        if (!s_valid_smp) begin
            if (r_streak != STREAK_MAX) begin
                n_streak = r_streak + 4'd1;
            end
            if (n_streak >= i_cfg.fault_samples) begin
                n_therm = 1'b1;
            end
        end else begin
            n_streak = '0;
            n_therm  = 1'b0;
        end

        if ((s_valid_smp && (r_in.temp_deci > s_max_safe)) || n_therm) begin
            n_heat = 1'b0;
            n_mode = MODE_FAULT;
        end

        case (n_mode)
            MODE_MENU: begin
                if (r_in.press_up && (n_menu != 3'd0)) begin
                    n_menu = n_menu - 3'd1;
                end
                if (r_in.press_down && (n_menu < MENU_LAST)) begin
                    n_menu = n_menu + 3'd1;
                end
                if (r_in.press_ok) begin
                    n_prof  = n_menu;
                    n_start = r_in.now_ms;
                    n_mode  = MODE_RUN;
                end
                if (r_in.press_back) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_RUN: begin
                if (s_valid_smp) begin
                    if (!n_heat && (s_temp14 < s_lo)) begin
                        n_heat = !n_therm;
                    end else if (n_heat && (s_temp14 > s_hi)) begin
                        n_heat = 1'b0;
                    end
                end else begin
                    n_heat = 1'b0;
                end
                if (s_timeout) begin
                    n_heat = 1'b0;
                    n_mode = MODE_DONE;
                end
                if (r_in.press_back) begin
                    n_heat = 1'b0;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_DONE: begin
                n_heat = 1'b0;
                if (r_in.press_ok) begin
                    n_mode = MODE_MENU;
                end
                if (r_in.press_back) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_FAULT: begin
                n_heat = 1'b0;
                if (r_in.press_back) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                n_heat = 1'b0;
                if (r_in.press_ok) begin
                    n_mode = MODE_MENU;
                end
            end
        endcase

        n_res.heater_drive = n_heat;
        n_res.mode_now     = mode_code(n_mode);
        n_res.menu_pos     = n_menu;
        n_res.sensor_fault = n_therm;
        n_res.is_run       = (n_mode == MODE_RUN);
        n_res.elapsed_ms   = r_in.now_ms - n_start;
        n_res.dur_s        = PROF_DUR_S[n_prof];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (i_tick.ready) begin
                r_v0 <= i_tick.valid;
            end
            if (s_adv_a) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.ready && i_tick.valid) begin
            r_in.adc_code   <= i_tick.adc_code;
            r_in.temp_deci  <= i_tick.temp_deci;
            r_in.now_ms     <= i_tick.now_ms;
            r_in.press_up   <= i_tick.press_up;
            r_in.press_down <= i_tick.press_down;
            r_in.press_ok   <= i_tick.press_ok;
            r_in.press_back <= i_tick.press_back;
        end
        if (s_take) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_menu   <= '0;
            r_prof   <= '0;
            r_start  <= '0;
            r_heat   <= 1'b0;
            r_streak <= '0;
            r_therm  <= 1'b0;
        end else if (s_take) begin
            r_mode   <= n_mode;
            r_menu   <= n_menu;
            r_prof   <= n_prof;
            r_start  <= n_start;
            r_heat   <= n_heat;
            r_streak <= n_streak;
            r_therm  <= n_therm;
        end
    end

    assign o_dn_valid = r_v1;
    assign o_dn       = r_res;

    a_heat_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heat |-> (r_mode == MODE_RUN))
        else $error("heater on outside run mode");

    a_latch_needs_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_therm |-> (r_streak != 4'd0))
        else $error("thermistor fault latched with empty streak");

    a_rail_extends_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_take && !s_valid_smp) |=> (r_streak != 4'd0))
        else $error("rail sample left streak at zero");

endmodule

[hdl/hpc_secs.sv]
// Remaining-seconds pipeline: reciprocal divide, correction and output register.
module hpc_secs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_up_valid,
    input  hpc_pkg::t_stage i_up,
    output logic            o_up_ready,
    hpc_result_if.source    o_res
);
    import hpc_pkg::*;

    logic        r_vb, r_vc, r_vd, r_ve;
    t_stage      r_b, r_c, r_d;
    logic [31:0] r_b_q0;
    logic [31:0] r_c_q0;
    logic [31:0] r_c_qm;
    logic [31:0] r_d_q;

    logic        r_e_heat;
    logic [2:0]  r_e_mode;
    logic [2:0]  r_e_menu;
    logic [15:0] r_e_left;
    logic        r_e_fault;

    logic        s_adv_b, s_adv_c, s_adv_d, s_adv_e;
    logic [63:0] s_prod_b;
    logic [63:0] s_prod_c;
    logic [31:0] s_rem;
    logic [31:0] n_q;
    logic [15:0] n_left;

    assign s_adv_e    = !r_ve || o_res.ready;
    assign s_adv_d    = !r_vd || s_adv_e;
    assign s_adv_c    = !r_vc || s_adv_d;
    assign s_adv_b    = !r_vb || s_adv_c;
    assign o_up_ready = s_adv_b;

    assign s_prod_b = 64'(i_up.elapsed_ms) * 64'(SEC_RECIP);
    assign s_prod_c = 64'(r_b_q0) * 64'(SEC_MS);
    assign s_rem    = r_c.elapsed_ms - r_c_qm;

    always_comb begin
        if (s_rem >= SEC_MS_X2) begin
            n_q = r_c_q0 + 32'd2;
        end else if (s_rem >= SEC_MS) begin
            n_q = r_c_q0 + 32'd1;
        end else begin
            n_q = r_c_q0;
        end
    end

    always_comb begin
        if (r_d.is_run && (r_d_q < 32'(r_d.dur_s))) begin
            n_left = r_d.dur_s - r_d_q[15:0];
        end else begin
            n_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (s_adv_b) r_vb <= i_up_valid;
            if (s_adv_c) r_vc <= r_vb;
            if (s_adv_d) r_vd <= r_vc;
            if (s_adv_e) r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv_b && i_up_valid) begin
            r_b    <= i_up;
            r_b_q0 <= s_prod_b[63:32];
        end
        if (s_adv_c && r_vb) begin
            r_c    <= r_b;
            r_c_q0 <= r_b_q0;
            r_c_qm <= s_prod_c[31:0];
        end
        if (s_adv_d && r_vc) begin
            r_d   <= r_c;
            r_d_q <= n_q;
        end
        if (s_adv_e && r_vd) begin
            r_e_heat  <= r_d.heater_drive;
            r_e_mode  <= r_d.mode_now;
            r_e_menu  <= r_d.menu_pos;
            r_e_left  <= n_left;
            r_e_fault <= r_d.sensor_fault;
        end
    end

    assign o_res.valid        = r_ve;
    assign o_res.heater_drive = r_e_heat;
    assign o_res.mode_now     = r_e_mode;
    assign o_res.menu_pos     = r_e_menu;
    assign o_res.seconds_left = r_e_left;
    assign o_res.sensor_fault = r_e_fault;

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc |-> (s_rem < SEC_MS_X3))
        else $error("reciprocal estimate out of correction range");

    a_left_zero_outside_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ve && (r_e_mode != MODE_CODE_RUN)) |-> (r_e_left == 16'd0))
        else $error("seconds left shown outside run mode");

    a_left_nonzero_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ve && (r_e_mode == MODE_CODE_RUN)) |-> (r_e_left != 16'd0))
        else $error("run mode word with no time left");

endmodule

[hdl/heater_profile_controller.sv]
// Top level of the heater profile controller.
//
//  channel   | dir | handshake     | word
//  i_tick    | in  | valid/ready   | adc_code, temp_deci, now_ms, press_up/down/ok/back
//  o_res     | out | valid/ready   | heater_drive, mode_now, menu_pos, seconds_left, sensor_fault
//  i_cfg_*   | in  | write enable  | register index and data, no read-back
//
//  One tick word is taken per cycle unless a stalled result backs up to the input register.
//  Input register, mode/heater update stage, then four stages that divide elapsed
//  milliseconds by a reciprocal multiply, correct the quotient and subtract it from the duration.
//  Reset clears the mode state and configuration to defaults; no clearing pass.
//  A stalled result holds; upstream words keep flowing into empty stages.
module heater_profile_controller (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hpc_tick_if.sink     i_tick,
    hpc_result_if.source o_res,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [10:0]  i_cfg_data
);
    import hpc_pkg::*;

    t_cfg   s_cfg;
    logic   s_mid_valid;
    t_stage s_mid;
    logic   s_mid_ready;

    hpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (s_cfg)
    );

    hpc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (i_tick),
        .i_cfg      (s_cfg),
        .o_dn_valid (s_mid_valid),
        .o_dn       (s_mid),
        .i_dn_ready (s_mid_ready)
    );

    hpc_secs u_secs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (s_mid_valid),
        .i_up       (s_mid),
        .o_up_ready (s_mid_ready),
        .o_res      (o_res)
    );

endmodule
